// ===== design/twsum_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twsum_pkg
// Shared widths, codes and types of the three-window forward sum block.
// ----------------------------------------------------------------------------
package twsum_pkg;

  // Field widths fixed by the record format
  localparam int unsigned POS_W = 32;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned SUM_W = 28;

  // Command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

  // Input item kinds
  typedef enum logic {
    KIND_RECORD = 1'b0,
    KIND_DRAIN  = 1'b1
  } kind_e;

  // Back-end read sequence: oldest entry, then the three window ends
  typedef enum logic [1:0] {
    STEP_BASE  = 2'd0,
    STEP_ONE   = 2'd1,
    STEP_SHORT = 2'd2,
    STEP_MID   = 2'd3
  } step_e;

endpackage
`default_nettype wire

// ===== design/triple_forward_window_sum.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triple_forward_window_sum
// Forward window sums over three lengths for a stream of (position, count)
// records, released in arrival order once the longest window has filled.
//
//   channel  signals                       direction  contents
//   in       in_valid_i / in_ready_o       to block   kind, position, count
//   out      out_valid_o / out_ready_i     from block position, count, sums, final
//
// A releasing request (full-ring record or drain) does one prefix-ring read
// per back-end step: oldest entry, then the unit, short and middle window
// ends; a record that only fills the ring needs just the base step. The
// result register loads from the finish flag after the last read unless the
// output stalls, and overlaps the next request. A 4-deep command queue lets
// input flow while the back end works or the output stalls. Reset clears
// pointers, counts and running prefix; used ring entries are written first.
// ----------------------------------------------------------------------------
module triple_forward_window_sum #(
  parameter int unsigned SHORT_WIN = 64,
  parameter int unsigned MID_WIN   = 512,
  parameter int unsigned LONG_WIN  = 4096
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         kind_i,
  input  wire logic [twsum_pkg::POS_W-1:0]  position_i,
  input  wire logic [twsum_pkg::CNT_W-1:0]  count_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [twsum_pkg::POS_W-1:0]  out_position_o,
  output logic      [twsum_pkg::CNT_W-1:0]  out_count_o,
  output logic      [twsum_pkg::SUM_W-1:0]  short_sum_o,
  output logic      [twsum_pkg::SUM_W-1:0]  mid_sum_o,
  output logic      [twsum_pkg::SUM_W-1:0]  long_sum_o,
  output logic                              final_record_o
);

  localparam int unsigned AW    = (LONG_WIN > 1) ? $clog2(LONG_WIN) : 1;
  localparam int unsigned CMD_W = 6 + 5 * AW + twsum_pkg::POS_W + 2 * twsum_pkg::SUM_W;

  logic             push;
  logic [CMD_W-1:0] push_cmd;
  logic             queue_full;
  logic             cmd_valid;
  logic [CMD_W-1:0] cmd;
  logic             pop;

  // Accept and classify requests
  twsum_front #(
    .SHORT_WIN (SHORT_WIN),
    .MID_WIN   (MID_WIN),
    .LONG_WIN  (LONG_WIN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .count_i      (count_i),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .queue_full_i (queue_full)
  );

  // Decouple front and back
  twsum_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (queue_full),
    .valid_o (cmd_valid),
    .data_o  (cmd),
    .pop_i   (pop)
  );

  // Execute ring accesses and form results
  twsum_back #(
    .LONG_WIN (LONG_WIN)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_position_o (out_position_o),
    .out_count_o    (out_count_o),
    .short_sum_o    (short_sum_o),
    .mid_sum_o      (mid_sum_o),
    .long_sum_o     (long_sum_o),
    .final_record_o (final_record_o)
  );

endmodule
`default_nettype wire

// ===== design/twsum_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twsum_queue
// Small register FIFO that carries commands from the front to the back.
// ----------------------------------------------------------------------------
module twsum_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  output logic                  valid_o,
  output logic      [WIDTH-1:0] data_o,
  input  wire logic             pop_i
);

  logic [WIDTH-1:0]                  entry_q [twsum_pkg::QUEUE_DEPTH];
  logic [twsum_pkg::QUEUE_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [twsum_pkg::QUEUE_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [twsum_pkg::QUEUE_AW:0]      fill_q, fill_d;

  localparam logic [twsum_pkg::QUEUE_AW:0] FILL_MAX =
      (twsum_pkg::QUEUE_AW + 1)'(twsum_pkg::QUEUE_DEPTH);

  assign full_o  = (fill_q == FILL_MAX);
  assign valid_o = (fill_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  // Advance pointers and fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (!push_i && pop_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/twsum_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twsum_front
// Accepts records and drain requests, tracks ring pointers, pending count
// and running prefix, and issues one command per item that needs the rings.
// ----------------------------------------------------------------------------
module twsum_front #(
  parameter int unsigned SHORT_WIN = 64,
  parameter int unsigned MID_WIN   = 512,
  parameter int unsigned LONG_WIN  = 4096,
  localparam int unsigned AW    = (LONG_WIN > 1) ? $clog2(LONG_WIN) : 1,
  localparam int unsigned CMD_W = 6 + 5 * AW + twsum_pkg::POS_W + 2 * twsum_pkg::SUM_W
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         kind_i,
  input  wire logic [twsum_pkg::POS_W-1:0]  position_i,
  input  wire logic [twsum_pkg::CNT_W-1:0]  count_i,
  output logic                              push_o,
  output logic      [CMD_W-1:0]             cmd_o,
  input  wire logic                         queue_full_i
);

  localparam int unsigned CW    = $clog2(LONG_WIN + 1);
  localparam int unsigned S_EFF = (SHORT_WIN > LONG_WIN) ? LONG_WIN : SHORT_WIN;
  localparam int unsigned M_EFF = (MID_WIN > LONG_WIN) ? LONG_WIN : MID_WIN;

  localparam logic [CW-1:0] RING_N  = CW'(LONG_WIN);
  localparam logic [CW-1:0] P_ONE   = CW'(1);
  localparam logic [CW-1:0] P_SHORT = CW'(S_EFF);
  localparam logic [CW-1:0] P_MID   = CW'(M_EFF);
  localparam logic [AW:0]   RING_K  = (AW + 1)'(LONG_WIN);
  localparam logic [AW:0]   K_ONE   = (AW + 1)'(1);
  localparam logic [AW:0]   K_SHORT = (AW + 1)'(S_EFF);
  localparam logic [AW:0]   K_MID   = (AW + 1)'(M_EFF);

  typedef struct packed {
    logic                            wr;
    logic                            rel;
    logic                            last;
    logic                            run_one;
    logic                            run_short;
    logic                            run_mid;
    logic [AW-1:0]                   wr_slot;
    logic [AW-1:0]                   head;
    logic [AW-1:0]                   slot_one;
    logic [AW-1:0]                   slot_short;
    logic [AW-1:0]                   slot_mid;
    logic [twsum_pkg::POS_W-1:0]     pos;
    logic [twsum_pkg::SUM_W-1:0]     pre;
    logic [twsum_pkg::SUM_W-1:0]     run;
  } cmd_t;

  // Ring slot k entries after base, k no larger than the ring
  function automatic logic [AW-1:0] slot_add(logic [AW-1:0] base, logic [AW:0] k);
    logic [AW:0] s;
    s = {1'b0, base} + k;
    if (s >= RING_K) begin
      s = s - RING_K;
    end
    return s[AW-1:0];
  endfunction

  logic [AW-1:0]               head_q, head_d;
  logic [AW-1:0]               tail_q, tail_d;
  logic [CW-1:0]               pending_q, pending_d;
  logic [twsum_pkg::SUM_W-1:0] running_q, running_d;
  logic [CW-1:0]               p_new;
  logic [CW-1:0]               rel_p;
  logic                        accept;
  cmd_t                        cmd;

  assign in_ready_o = !queue_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign p_new      = pending_q + 1'b1;
  assign cmd_o      = cmd;

  // Classify the request and build its command
  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    pending_d = pending_q;
    running_d = running_q;
    push_o    = 1'b0;
    rel_p     = pending_q;

    cmd            = '0;
    cmd.wr_slot    = tail_q;
    cmd.head       = head_q;
    cmd.slot_one   = slot_add(head_q, K_ONE);
    cmd.slot_short = slot_add(head_q, K_SHORT);
    cmd.slot_mid   = slot_add(head_q, K_MID);
    cmd.pos        = position_i;
    cmd.pre        = running_q;
    cmd.run        = running_q;

    if (kind_i == twsum_pkg::KIND_RECORD) begin
      rel_p     = p_new;
      cmd.wr    = 1'b1;
      cmd.rel   = (p_new == RING_N);
      cmd.run   = running_q + twsum_pkg::SUM_W'(count_i);
      if (accept) begin
        push_o    = 1'b1;
        tail_d    = slot_add(tail_q, K_ONE);
        running_d = cmd.run;
        if (cmd.rel) begin
          head_d = slot_add(head_q, K_ONE);
        end else begin
          pending_d = p_new;
        end
      end
    end else begin
      cmd.rel  = (pending_q != '0);
      cmd.last = (pending_q == P_ONE);
      if (accept && cmd.rel) begin
        push_o    = 1'b1;
        head_d    = slot_add(head_q, K_ONE);
        pending_d = pending_q - 1'b1;
      end
    end

    // A window end past the newest record takes the running prefix
    cmd.run_one   = (rel_p <= P_ONE);
    cmd.run_short = (rel_p <= P_SHORT);
    cmd.run_mid   = (rel_p <= P_MID);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      pending_q <= '0;
      running_q <= '0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      pending_q <= pending_d;
      running_q <= running_d;
    end
  end

  // Pending records never fill the whole ring between requests
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q < RING_N)
    else $error("pending count reached ring depth");

  // The tail advances on every accepted record, staying pending entries after the head
  a_tail_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && push_o && (kind_i == twsum_pkg::KIND_RECORD) |=>
      tail_q != $past(tail_q) || RING_K == K_ONE)
    else $error("tail did not advance on a record");

endmodule
`default_nettype wire

// ===== design/twsum_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twsum_back
// Executes commands: writes the position and prefix rings, reads the oldest
// entry and three window ends, and forms the window sums into a result
// register.
// ----------------------------------------------------------------------------
module twsum_back #(
  parameter int unsigned LONG_WIN = 4096,
  localparam int unsigned AW    = (LONG_WIN > 1) ? $clog2(LONG_WIN) : 1,
  localparam int unsigned CMD_W = 6 + 5 * AW + twsum_pkg::POS_W + 2 * twsum_pkg::SUM_W
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cmd_valid_i,
  input  wire logic [CMD_W-1:0]             cmd_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [twsum_pkg::POS_W-1:0]  out_position_o,
  output logic      [twsum_pkg::CNT_W-1:0]  out_count_o,
  output logic      [twsum_pkg::SUM_W-1:0]  short_sum_o,
  output logic      [twsum_pkg::SUM_W-1:0]  mid_sum_o,
  output logic      [twsum_pkg::SUM_W-1:0]  long_sum_o,
  output logic                              final_record_o
);

  typedef struct packed {
    logic                            wr;
    logic                            rel;
    logic                            last;
    logic                            run_one;
    logic                            run_short;
    logic                            run_mid;
    logic [AW-1:0]                   wr_slot;
    logic [AW-1:0]                   head;
    logic [AW-1:0]                   slot_one;
    logic [AW-1:0]                   slot_short;
    logic [AW-1:0]                   slot_mid;
    logic [twsum_pkg::POS_W-1:0]     pos;
    logic [twsum_pkg::SUM_W-1:0]     pre;
    logic [twsum_pkg::SUM_W-1:0]     run;
  } cmd_t;

  cmd_t cmd;
  assign cmd = cmd_t'(cmd_i);

  // Rings of positions and prefix sums
  logic [twsum_pkg::POS_W-1:0] pos_mem [LONG_WIN];
  logic [twsum_pkg::SUM_W-1:0] pre_mem [LONG_WIN];
  logic [twsum_pkg::POS_W-1:0] pos_rd_q;
  logic [twsum_pkg::SUM_W-1:0] pre_rd_q;

  twsum_pkg::step_e            step_q, step_d;
  logic                        fin_q, fin_d;
  logic                        hit_q, hit_d;
  logic                        stall;
  logic                        adv;
  logic                        wr_en;
  logic                        pre_rd_en;
  logic                        pos_rd_en;
  logic [AW-1:0]               pre_rd_addr;
  logic                        base_en;
  logic                        one_en;
  logic                        short_en;
  logic                        tail_en;

  logic [twsum_pkg::SUM_W-1:0] base_q;
  logic [twsum_pkg::POS_W-1:0] pos_q;
  logic [twsum_pkg::SUM_W-1:0] one_q;
  logic [twsum_pkg::SUM_W-1:0] short_q;
  logic [twsum_pkg::SUM_W-1:0] run_q;
  logic                        run_one_q;
  logic                        run_short_q;
  logic                        run_mid_q;
  logic                        last_q;

  logic [twsum_pkg::SUM_W-1:0] end_one;
  logic [twsum_pkg::SUM_W-1:0] end_short;
  logic [twsum_pkg::SUM_W-1:0] end_mid;
  logic [twsum_pkg::SUM_W-1:0] one_diff;
  logic                        out_valid_q, out_valid_d;
  logic                        out_load;

  // Hold everything while a finished result cannot leave
  assign stall    = fin_q && out_valid_q && !out_ready_i;
  assign adv      = !stall;
  assign out_load = fin_q && adv;

  // Step through the read sequence
  always_comb begin
    step_d      = step_q;
    fin_d       = adv ? 1'b0 : fin_q;
    hit_d       = adv ? 1'b0 : hit_q;
    pop_o       = 1'b0;
    wr_en       = 1'b0;
    pre_rd_en   = 1'b0;
    pos_rd_en   = 1'b0;
    pre_rd_addr = cmd.head;
    base_en     = 1'b0;
    one_en      = 1'b0;
    short_en    = 1'b0;
    tail_en     = 1'b0;
    if (cmd_valid_i && adv) begin
      case (step_q)
        twsum_pkg::STEP_BASE: begin
          wr_en = cmd.wr;
          if (cmd.rel) begin
            pre_rd_en = 1'b1;
            pos_rd_en = 1'b1;
            hit_d     = cmd.wr && (cmd.wr_slot == cmd.head);
            step_d    = twsum_pkg::STEP_ONE;
          end else begin
            pop_o = 1'b1;
          end
        end
        twsum_pkg::STEP_ONE: begin
          pre_rd_en   = 1'b1;
          pre_rd_addr = cmd.slot_one;
          base_en     = 1'b1;
          step_d      = twsum_pkg::STEP_SHORT;
        end
        twsum_pkg::STEP_SHORT: begin
          pre_rd_en   = 1'b1;
          pre_rd_addr = cmd.slot_short;
          one_en      = 1'b1;
          step_d      = twsum_pkg::STEP_MID;
        end
        twsum_pkg::STEP_MID: begin
          pre_rd_en   = 1'b1;
          pre_rd_addr = cmd.slot_mid;
          short_en    = 1'b1;
          tail_en     = 1'b1;
          pop_o       = 1'b1;
          fin_d       = 1'b1;
          step_d      = twsum_pkg::STEP_BASE;
        end
        default: begin
          step_d = twsum_pkg::STEP_BASE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= twsum_pkg::STEP_BASE;
      fin_q       <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      fin_q       <= fin_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Write and read the rings
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pos_mem[cmd.wr_slot] <= cmd.pos;
    end
    if (pos_rd_en) begin
      pos_rd_q <= pos_mem[cmd.head];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pre_mem[cmd.wr_slot] <= cmd.pre;
    end
    if (pre_rd_en) begin
      pre_rd_q <= pre_mem[pre_rd_addr];
    end
  end

  // Capture the oldest entry and the unit and short window ends; bypass a same-cycle write
  always_ff @(posedge clk_i) begin
    if (base_en) begin
      base_q <= hit_q ? cmd.pre : pre_rd_q;
      pos_q  <= hit_q ? cmd.pos : pos_rd_q;
    end
    if (one_en) begin
      one_q <= pre_rd_q;
    end
    if (short_en) begin
      short_q <= pre_rd_q;
    end
    if (tail_en) begin
      run_q       <= cmd.run;
      run_one_q   <= cmd.run_one;
      run_short_q <= cmd.run_short;
      run_mid_q   <= cmd.run_mid;
      last_q      <= cmd.last;
    end
  end

  // Form window sums as prefix differences
  assign end_one   = run_one_q   ? run_q : one_q;
  assign end_short = run_short_q ? run_q : short_q;
  assign end_mid   = run_mid_q   ? run_q : pre_rd_q;
  assign one_diff  = end_one - base_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_position_o <= pos_q;
      out_count_o    <= one_diff[twsum_pkg::CNT_W-1:0];
      short_sum_o    <= end_short - base_q;
      mid_sum_o      <= end_mid - base_q;
      long_sum_o     <= run_q - base_q;
      final_record_o <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;

  // A read sequence only runs with its command still at the queue head
  a_cmd_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q != twsum_pkg::STEP_BASE |-> cmd_valid_i)
    else $error("read sequence without a command");

  // A finishing result is consumed unless the output stalls
  a_fin_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q && !stall |=> !fin_q)
    else $error("finish stage held without a stall");

  // The write bypass applies only to the capture of the oldest entry
  a_hit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> step_q == twsum_pkg::STEP_ONE)
    else $error("ring bypass flag outside the base capture");

endmodule
`default_nettype wire
